// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the RTL. Both forms sample on
// the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while rst_n is low.
`define ASSERT_CLK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that also holds while reset is applied.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/adm_pkg.sv =====
// ----------------------------------------------------------------------------
// adm_pkg
// Command codes, register indexes and the command bundle that the admittance
// controller's sequencer sends to its datapath.
// ----------------------------------------------------------------------------
package adm_pkg;

  // Number of fractional bits of every fixed-point word.
  localparam int FRAC_BITS = 16;

  // Configuration register file.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODEL_A00  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MODEL_A01  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MODEL_A10  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MODEL_A11  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FORCE_B0   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FORCE_B1   = 3'd7;

  // Datapath operations.
  localparam int CMD_W = 4;

  localparam logic [CMD_W-1:0] CMD_NONE   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ERR1   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MAG    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MUL_LO = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MUL_HI = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RND    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ACC    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_NEW    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ERR2   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_DONE   = 4'd10;

  // Product selectors, in the order the sequencer walks them.
  localparam int PROD_W = 3;

  localparam logic [PROD_W-1:0] PROD_A00_EX = 3'd0;
  localparam logic [PROD_W-1:0] PROD_A01_EV = 3'd1;
  localparam logic [PROD_W-1:0] PROD_B0_F   = 3'd2;
  localparam logic [PROD_W-1:0] PROD_A10_EX = 3'd3;
  localparam logic [PROD_W-1:0] PROD_A11_EV = 3'd4;
  localparam logic [PROD_W-1:0] PROD_B1_F   = 3'd5;
  localparam logic [PROD_W-1:0] PROD_P_EX   = 3'd6;
  localparam logic [PROD_W-1:0] PROD_D_EV   = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [PROD_W-1:0] prod;
  } adm_cmd_t;

endpackage

// ===== hw/rtl/adm_ctrl.sv =====
// ----------------------------------------------------------------------------
// adm_ctrl
// Sequencer of the admittance controller: takes a word, walks the datapath
// through its fixed schedule of products and hands the result word out.
// ----------------------------------------------------------------------------
module adm_ctrl import adm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output adm_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR1 = 4'd1;
  localparam logic [3:0] ST_MAG  = 4'd2;
  localparam logic [3:0] ST_LO   = 4'd3;
  localparam logic [3:0] ST_HI   = 4'd4;
  localparam logic [3:0] ST_RND  = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_NEW  = 4'd7;
  localparam logic [3:0] ST_ERR2 = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              done_go;

  // The result register may be refilled once the waiting word leaves.
  assign done_go   = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = CMD_NONE;
    cmd.prod      = prod_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = CMD_LOAD;
          prod_nxt  = PROD_A00_EX;
          state_nxt = ST_ERR1;
        end
      end
      ST_ERR1: begin
        cmd.op    = CMD_ERR1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.op    = CMD_MAG;
        state_nxt = ST_LO;
      end
      ST_LO: begin
        cmd.op    = CMD_MUL_LO;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        cmd.op    = CMD_MUL_HI;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.op    = CMD_RND;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = CMD_ACC;
        priority if (prod_r == PROD_B1_F) begin
          state_nxt = ST_NEW;
        end else if (prod_r == PROD_D_EV) begin
          state_nxt = ST_DONE;
        end else begin
          prod_nxt  = prod_r + 1'b1;
          state_nxt = ST_MAG;
        end
      end
      ST_NEW: begin
        cmd.op    = CMD_NEW;
        prod_nxt  = PROD_P_EX;
        state_nxt = ST_ERR2;
      end
      ST_ERR2: begin
        cmd.op    = CMD_ERR2;
        state_nxt = ST_MAG;
      end
      ST_DONE: begin
        if (done_go) begin
          cmd.op        = CMD_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prod_r      <= PROD_A00_EX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prod_r      <= prod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/adm_datapath.sv =====
// ----------------------------------------------------------------------------
// adm_datapath
// Register file, model state and one shared fixed-point multiply unit of the
// admittance controller. Every step is selected by the sequencer's command.
// ----------------------------------------------------------------------------
module adm_datapath import adm_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adm_cmd_t                     cmd,
  input  logic                         cfg_wr_en,
  input  logic [REG_IDX_W-1:0]         cfg_index,
  input  logic [WORD_WIDTH-1:0]        cfg_data,
  input  logic [5*WORD_WIDTH-1:0]      in_fields,
  output logic signed [WORD_WIDTH-1:0] drive_command,
  output logic signed [WORD_WIDTH-1:0] model_position,
  output logic signed [WORD_WIDTH-1:0] model_velocity
);

  localparam int W  = WORD_WIDTH;
  localparam int H  = (W + 1) / 2;        // low slice of the second operand
  localparam int PW = 2 * W;              // full product
  localparam int QW = 2 * W - FRAC_BITS;  // product after scaling
  localparam int AW = W + 3;              // sum of three saturated products
  localparam int SW = W + 4;              // headroom for any difference

  localparam logic [PW-1:0] HALF_LSB = PW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0] MAG_LIM  = QW'(1) << (W - 1);
  localparam logic [W-1:0]  MAG_NEG  = W'(1) << (W - 1);
  localparam logic [W-1:0]  MAG_POS  = MAG_NEG - 1'b1;

  function automatic logic signed [W-1:0] sat_word(input logic signed [SW-1:0] x);
    logic fits;
    fits = (&x[SW-1:W-1]) || !(|x[SW-1:W-1]);
    if (fits) begin
      return x[W-1:0];
    end
    return x[SW-1] ? $signed(MAG_NEG) : $signed(MAG_POS);
  endfunction

  logic        [W-1:0]  cfg_r [NUM_REGS];
  logic signed [W-1:0]  vp_r, vv_r;
  logic signed [W-1:0]  dx_r, dv_r, mx_r, mv_r, frc_r;
  logic signed [W-1:0]  ex_r, ev_r;
  logic        [W-1:0]  ma_r, mb_r;
  logic                 neg_r;
  logic        [PW-1:0] prod_r;
  logic        [QW-1:0] q_r;
  logic signed [AW-1:0] acc0_r, acc1_r;
  logic signed [W-1:0]  cmd_out_r, pos_out_r, vel_out_r;

  logic signed [W-1:0]  opa, opb;
  logic        [H-1:0]  mul_b;
  logic        [W+H-1:0] mul_p;
  logic        [W-1:0]  mag;
  logic        [AW-1:0] mag_ext, term, acc_sel, acc_sum;
  logic                 to_acc1;

  // Operand routing for the selected product.
  always_comb begin
    unique case (cmd.prod)
      PROD_A00_EX: begin opa = cfg_r[REG_MODEL_A00];  opb = ex_r;  end
      PROD_A01_EV: begin opa = cfg_r[REG_MODEL_A01];  opb = ev_r;  end
      PROD_B0_F:   begin opa = cfg_r[REG_FORCE_B0];   opb = frc_r; end
      PROD_A10_EX: begin opa = cfg_r[REG_MODEL_A10];  opb = ex_r;  end
      PROD_A11_EV: begin opa = cfg_r[REG_MODEL_A11];  opb = ev_r;  end
      PROD_B1_F:   begin opa = cfg_r[REG_FORCE_B1];   opb = frc_r; end
      PROD_P_EX:   begin opa = cfg_r[REG_PROP_GAIN];  opb = ex_r;  end
      PROD_D_EV:   begin opa = cfg_r[REG_DERIV_GAIN]; opb = ev_r;  end
      default:     begin opa = cfg_r[REG_PROP_GAIN];  opb = ex_r;  end
    endcase
  end

  assign to_acc1 = (cmd.prod == PROD_A10_EX) || (cmd.prod == PROD_A11_EV) ||
                   (cmd.prod == PROD_B1_F);

  // One unsigned W x H multiplier, used for the low and then the high slice.
  assign mul_b = (cmd.op == CMD_MUL_HI) ? H'(mb_r >> H) : mb_r[H-1:0];
  assign mul_p = ma_r * mul_b;

  // Saturate the scaled magnitude, then add it with its sign.
  assign mag     = (q_r >= MAG_LIM) ? (neg_r ? MAG_NEG : MAG_POS) : q_r[W-1:0];
  assign mag_ext = AW'(mag);
  assign term    = neg_r ? ~mag_ext : mag_ext;
  assign acc_sel = to_acc1 ? acc1_r : acc0_r;
  assign acc_sum = acc_sel + term + AW'(neg_r);

  // Configuration and model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= '0;
      end
      vp_r <= '0;
      vv_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (cmd.op == CMD_NEW) begin
        vp_r <= sat_word(SW'(dx_r) - SW'(acc0_r));
        vv_r <= sat_word(SW'(dv_r) - SW'(acc1_r));
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        dx_r   <= in_fields[0*W +: W];
        dv_r   <= in_fields[1*W +: W];
        mx_r   <= in_fields[2*W +: W];
        mv_r   <= in_fields[3*W +: W];
        frc_r  <= in_fields[4*W +: W];
        acc0_r <= '0;
        acc1_r <= '0;
      end
      CMD_ERR1: begin
        ex_r <= sat_word(SW'(dx_r) - SW'(vp_r));
        ev_r <= sat_word(SW'(dv_r) - SW'(vv_r));
      end
      CMD_MAG: begin
        ma_r  <= opa[W-1] ? (~opa + 1'b1) : opa;
        mb_r  <= opb[W-1] ? (~opb + 1'b1) : opb;
        neg_r <= opa[W-1] ^ opb[W-1];
      end
      CMD_MUL_LO: begin
        prod_r <= PW'(mul_p);
      end
      CMD_MUL_HI: begin
        prod_r <= prod_r + (PW'(mul_p) << H);
      end
      CMD_RND: begin
        q_r <= QW'((prod_r + HALF_LSB) >> FRAC_BITS);
      end
      CMD_ACC: begin
        if (to_acc1) begin
          acc1_r <= $signed(acc_sum);
        end else begin
          acc0_r <= $signed(acc_sum);
        end
      end
      CMD_NEW: begin
        acc0_r <= '0;
      end
      CMD_ERR2: begin
        ex_r <= sat_word(SW'(vp_r) - SW'(mx_r));
        ev_r <= sat_word(SW'(vv_r) - SW'(mv_r));
      end
      CMD_DONE: begin
        cmd_out_r <= sat_word(SW'(acc0_r));
        pos_out_r <= vp_r;
        vel_out_r <= vv_r;
      end
      default: begin
      end
    endcase
  end

  assign drive_command  = cmd_out_r;
  assign model_position = pos_out_r;
  assign model_velocity = vel_out_r;

endmodule

// ===== hw/rtl/admittance_controller_core.sv =====
// ----------------------------------------------------------------------------
// admittance_controller_core
// Admittance model with a PD inner loop in signed fixed point (16 fraction
// bits), one drive word per control tick.
// ----------------------------------------------------------------------------
// Each input word carries the desired position and velocity and the measured
// position, velocity and force. The block advances its virtual model state by
// a 2x2 state matrix and a force weight vector, both taken relative to the
// desired values, and then applies a PD law toward the new model state. All
// differences and final sums saturate to the word range, and each product is
// scaled by 2^-16 with the magnitude rounded half away from zero. Per word,
// eight products pass one after another through a single shared multiplier,
// each in five steps (magnitude, low and high partial product, rounding,
// signed accumulate), plus steps for loading, the error terms, the model
// update and the output register, which waits while an earlier result is
// unread; no new word is taken before it ends. The result word sits in an
// output register, so the next input word is taken while it waits. The model
// state resets to zero; gains and matrix entries reset to zero. The user must
// write them through the cfg port only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module admittance_controller_core import adm_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port; index 0..7 selects the register.
  input  logic                                   cfg_wr_en,
  input  logic [REG_IDX_W-1:0]                   cfg_index,
  input  logic [WORD_WIDTH-1:0]                  cfg_data,
  // Input word.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // From bit 0 up: desired_position, desired_velocity, measured_position,
  // measured_velocity, measured_force, zero padding to a whole byte.
  input  logic [((5*WORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  // Result word.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // From bit 0 up: drive_command, model_position, model_velocity, zero
  // padding to a whole byte.
  output logic [((3*WORD_WIDTH+7)/8)*8-1:0]      out_tdata
);

  localparam int IN_TDW  = ((5*WORD_WIDTH+7)/8)*8;
  localparam int OUT_TDW = ((3*WORD_WIDTH+7)/8)*8;

  adm_cmd_t                      cmd;
  logic signed [WORD_WIDTH-1:0]  drive_command;
  logic signed [WORD_WIDTH-1:0]  model_position;
  logic signed [WORD_WIDTH-1:0]  model_velocity;

  // The sequencer owns the handshakes and the step schedule.
  adm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath holds the registers, the model state and the multiplier.
  adm_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_fields      (in_tdata[5*WORD_WIDTH-1:0]),
    .drive_command  (drive_command),
    .model_position (model_position),
    .model_velocity (model_velocity)
  );

  // Pack the result fields; any padding bits read as zero.
  assign out_tdata = OUT_TDW'({model_velocity, model_position, drive_command});

  // A word is loaded exactly when the input handshake completes.
  `ASSERT_CLK_RST(a_load_on_accept, (in_tvalid && in_tready) == (cmd.op == CMD_LOAD) || (IN_TDW == 0), "load command does not match input handshake")

  // Once a word is taken, the block is busy on the following cycle.
  `ASSERT_CLK_RST(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "input accepted while still busy")

  // The output register is refilled only when it is free or being drained.
  `ASSERT_CLK_RST(a_no_overwrite, cmd.op == CMD_DONE |-> !out_tvalid || out_tready, "waiting result overwritten")

  // A result appears only right after the datapath wrote the output register.
  `ASSERT_CLK_RST(a_valid_after_done, $rose(out_tvalid) |-> $past(cmd.op == CMD_DONE), "result valid without a finished word")

endmodule
